[rtl/core/nes_pkg.sv]
// package for the neighbourhood edge strength block
// types, constants and arithmetic helpers; no dependencies
package nes_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ChanMax   = 32768;
  localparam int unsigned StoreLen  = 2 * MaxWidth + 3;
  localparam int unsigned AddrW     = $clog2(StoreLen);
  localparam int unsigned PosW      = $clog2(MaxWidth * MaxHeight + MaxWidth + 2);
  localparam int unsigned ColW      = $clog2(MaxWidth + 1);
  localparam int unsigned RowW      = $clog2(MaxHeight + 2);

  // configuration register indexes
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegLvlOn  = 3'd2;
  localparam logic [2:0] RegAlpOn  = 3'd3;
  localparam logic [2:0] RegLvlGn  = 3'd4;
  localparam logic [2:0] RegAlpGn  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_NB0, ST_NB1, ST_NB2, ST_NB3, ST_NB4, ST_NB5,
    ST_NB6, ST_NB7, ST_NB8, ST_MUL, ST_MIX, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       start;     // accept item, latch fields
    logic       wr;        // write row store
    logic [3:0] slot;      // neighbour slot being read, 9 = none
    logic       rd;        // issue read of slot
    logic       acc;       // accumulate data from previous read
    logic       mul;
    logic       mix;
    logic       done;      // advance position
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_out;  // item produces a centre
  } stat_t;

  function automatic logic [15:0] level_of(input logic [15:0] r, input logic [15:0] g,
                                           input logic [15:0] b, input logic [15:0] a);
    logic [15:0] mx, mn;
    logic [16:0] s;
    logic [31:0] p;
    logic [16:0] l;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    s  = ({1'b0, mx} + {1'b0, mn}) >> 1;
    p  = s[15:0] * a;
    l  = p[31:15];
    if (a == 16'd0) return 16'd0;
    if (l > 17'(ChanMax)) return 16'(ChanMax);
    return l[15:0];
  endfunction

endpackage

[rtl/core/neighbourhood_edge_strength.sv]
// 3x3 neighbourhood edge strength: after the transaction that completes its
// neighbourhood, a result is formed by the neighbour scan, multiply and mix states
// and is held until taken; a new transaction is taken only in the idle state, so
// each waits for the previous one's scan, gain math and output; the pace is set by
// the serial neighbour scan through the single read port of the row store
// reset clears position and control state; the row store holds garbage until written
module neighbourhood_edge_strength (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic [15:0] opacity_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] edge_alpha_o,
  output logic        frame_end_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  logic [12:0] fw_q, fh_q, lg_q, ag_q;
  logic        lo_q, ao_q, emit, unused_op;
  nes_pkg::cmd_t  cmd;
  nes_pkg::stat_t stat;

  assign cfg_ready = 1'b1;
  assign unused_op = op_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 13'd1; fh_q <= 13'd1; lo_q <= 1'b0; ao_q <= 1'b0;
      lg_q <= 13'd4096; ag_q <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        nes_pkg::RegWidth:  fw_q <= cfg_data_i;
        nes_pkg::RegHeight: fh_q <= cfg_data_i;
        nes_pkg::RegLvlOn:  lo_q <= cfg_data_i[0];
        nes_pkg::RegAlpOn:  ao_q <= cfg_data_i[0];
        nes_pkg::RegLvlGn:  lg_q <= cfg_data_i;
        nes_pkg::RegAlpGn:  ag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nes_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .emit_i(emit), .stat_i(stat), .cmd_o(cmd)
  );

  nes_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .red_i, .green_i, .blue_i, .opacity_i,
    .frame_width_i(fw_q), .frame_height_i(fh_q),
    .level_mode_on_i(lo_q), .alpha_mode_on_i(ao_q),
    .level_gain_i(lg_q), .alpha_gain_i(ag_q),
    .emit_o(emit), .edge_alpha_o, .frame_end_o
  );

`ifndef NO_ASSERTIONS
  // no input taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid |-> in_stall)
    else $error("input accepted with result pending");
  // a result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(edge_alpha_o))
    else $error("result dropped");
  // result never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> edge_alpha_o <= 16'd32768)
    else $error("edge out of range");
`endif
endmodule

[rtl/core/nes_ram.sv]
// generic single port write, single port read ram with registered read
// no dependencies
module nes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[rtl/core/nes_ctrl.sv]
// controller for the edge strength block
// depends on nes_pkg
module nes_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  logic            emit_i,
  input  nes_pkg::stat_t  stat_i,
  output nes_pkg::cmd_t   cmd_o
);
  nes_pkg::state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nes_pkg::ST_IDLE: if (in_valid) state_d = nes_pkg::ST_RD;
      nes_pkg::ST_RD:   state_d = stat_i.has_out ? nes_pkg::ST_NB0 : nes_pkg::ST_IDLE;
      nes_pkg::ST_NB8:  state_d = nes_pkg::ST_MUL;
      nes_pkg::ST_MUL:  state_d = nes_pkg::ST_MIX;
      nes_pkg::ST_MIX:  state_d = emit_i ? nes_pkg::ST_OUT : nes_pkg::ST_IDLE;
      nes_pkg::ST_OUT:  if (!out_stall) state_d = nes_pkg::ST_IDLE;
      default: begin
        if (state_q inside {[nes_pkg::ST_NB0:nes_pkg::ST_NB7]})
          state_d = nes_pkg::state_e'(state_q + 4'd1);
        else state_d = nes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= nes_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // outputs; the first scan state takes in the centre read issued during the store write
  always_comb begin
    cmd_o     = '0;
    cmd_o.slot = 4'd9;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      nes_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd_o.start = in_valid;
      end
      nes_pkg::ST_RD: begin
        cmd_o.wr   = 1'b1;
        cmd_o.done = !stat_i.has_out;
        cmd_o.rd   = 1'b1;
        cmd_o.slot = 4'd4;
      end
      nes_pkg::ST_NB8: cmd_o.acc = 1'b1;
      nes_pkg::ST_MUL: cmd_o.mul = 1'b1;
      nes_pkg::ST_MIX: begin
        cmd_o.mix  = 1'b1;
        cmd_o.done = 1'b1;
      end
      nes_pkg::ST_OUT: out_valid = 1'b1;
      default: begin
        cmd_o.acc  = 1'b1;
        cmd_o.rd   = 1'b1;
        cmd_o.slot = 4'(state_q - nes_pkg::ST_NB0);
        if (cmd_o.slot >= 4'd4) cmd_o.slot = cmd_o.slot + 4'd1;
      end
    endcase
  end
endmodule

[rtl/core/nes_dp.sv]
// datapath: sequence position, row store, neighbour scan and gain math
// depends on nes_pkg and nes_ram
module nes_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nes_pkg::cmd_t            cmd_i,
  output nes_pkg::stat_t           stat_o,
  input  logic [15:0]              red_i,
  input  logic [15:0]              green_i,
  input  logic [15:0]              blue_i,
  input  logic [15:0]              opacity_i,
  input  logic [12:0]              frame_width_i,
  input  logic [12:0]              frame_height_i,
  input  logic                     level_mode_on_i,
  input  logic                     alpha_mode_on_i,
  input  logic [12:0]              level_gain_i,
  input  logic [12:0]              alpha_gain_i,
  output logic                     emit_o,
  output logic [15:0]              edge_alpha_o,
  output logic                     frame_end_o
);
  localparam int unsigned AW = nes_pkg::AddrW;
  localparam int unsigned PW = nes_pkg::PosW;

  logic [nes_pkg::ColW-1:0] w_q, col_q;
  logic [nes_pkg::RowW-1:0] h_q, row_q;
  logic [PW-1:0] c_q, total_q;
  logic [nes_pkg::ColW-1:0] x_q;   // centre column
  logic [nes_pkg::RowW-1:0] y_q;   // centre row
  logic [AW-1:0] wa_q, qa_q;       // store address of item, of centre
  logic [31:0]   wdata_q;
  logic [15:0]   pl_q, pa_q;
  logic [16:0]   dl_q, da_q;
  logic [28:0]   p0_q, p1_q;
  logic [3:0]    pslot_q;
  logic          pin_q;
  logic          has_q;
  logic [15:0]   res_q;
  logic          fe_q;

  // latched frame size at first item
  logic [12:0] wcl, hcl;
  always_comb begin
    wcl = (frame_width_i == 13'd0) ? 13'd1 :
          (frame_width_i > 13'(nes_pkg::MaxWidth)) ? 13'(nes_pkg::MaxWidth) : frame_width_i;
    hcl = (frame_height_i == 13'd0) ? 13'd1 :
          (frame_height_i > 13'(nes_pkg::MaxHeight)) ? 13'(nes_pkg::MaxHeight)
          : frame_height_i;
  end

  logic first;
  assign first = (col_q == '0) && (row_q == '0);

  logic [nes_pkg::ColW-1:0] w_n;
  logic [nes_pkg::RowW-1:0] h_n;
  assign w_n = first ? nes_pkg::ColW'(wcl) : w_q;
  assign h_n = first ? nes_pkg::RowW'(hcl) : h_q;

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input logic [AW:0] d);
    logic [AW:0] s;
    s = {1'b0, a} + d;
    if (s >= (AW+1)'(nes_pkg::StoreLen)) s = s - (AW+1)'(nes_pkg::StoreLen);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_sub(input logic [AW-1:0] a, input logic [AW:0] d);
    logic [AW:0] s;
    s = {1'b0, a} - d;
    if (s[AW]) s = s + (AW+1)'(nes_pkg::StoreLen);
    return s[AW-1:0];
  endfunction

  // item intake: position, store write data, centre
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= nes_pkg::ColW'(1); h_q <= nes_pkg::RowW'(1);
      col_q <= '0; row_q <= '0; c_q <= '0; total_q <= PW'(1);
      x_q <= '0; y_q <= '0; wa_q <= '0; qa_q <= '0; has_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        w_q <= w_n;
        h_q <= h_n;
        if (first) begin
          c_q     <= '0;
          wa_q    <= '0;
          total_q <= PW'(w_n) * PW'(h_n);
          x_q <= '0; y_q <= '0;
          qa_q <= '0;
        end
        has_q <= first ? (w_n == '0) : ({1'b0, c_q} >= (PW+1)'({1'b0, w_q} + 1'b1));
      end
      if (cmd_i.done) begin
        if (c_q >= total_q + PW'(w_q)) begin
          col_q <= '0; row_q <= '0;
        end else if (col_q + 1'b1 >= w_q) begin
          col_q <= '0; row_q <= row_q + 1'b1;
        end else col_q <= col_q + 1'b1;
        c_q  <= c_q + 1'b1;
        wa_q <= addr_add(wa_q, (AW+1)'(1));
        if (has_q) begin
          qa_q <= addr_add(qa_q, (AW+1)'(1));
          if (x_q + 1'b1 >= w_q) begin
            x_q <= '0; y_q <= y_q + 1'b1;
          end else x_q <= x_q + 1'b1;
        end
      end
    end
  end

  assign stat_o.has_out = has_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start)
      wdata_q <= {opacity_i, nes_pkg::level_of(red_i, green_i, blue_i, opacity_i)};
  end

  // neighbour address and in-frame test
  logic [AW-1:0] raddr;
  logic          inb;
  logic [31:0]   rdata;
  logic [1:0]    dy, dx;
  always_comb begin
    if (cmd_i.slot inside {4'd0, 4'd1, 4'd2}) dy = 2'd0;
    else if (cmd_i.slot inside {4'd3, 4'd4, 4'd5}) dy = 2'd1;
    else dy = 2'd2;
    if (cmd_i.slot inside {4'd0, 4'd3, 4'd6}) dx = 2'd0;
    else if (cmd_i.slot inside {4'd2, 4'd5, 4'd8}) dx = 2'd2;
    else dx = 2'd1;
    inb = 1'b1;
    if (dx == 2'd0 && x_q == '0) inb = 1'b0;
    if (dx == 2'd2 && x_q + 1'b1 >= w_q) inb = 1'b0;
    if (dy == 2'd0 && y_q == '0) inb = 1'b0;
    if (dy == 2'd2 && y_q + 1'b1 >= h_q) inb = 1'b0;
    raddr = qa_q;
    if (dy == 2'd0) raddr = addr_sub(raddr, (AW+1)'(w_q));
    if (dy == 2'd2) raddr = addr_add(raddr, (AW+1)'(w_q));
    if (dx == 2'd0) raddr = addr_sub(raddr, (AW+1)'(1));
    if (dx == 2'd2) raddr = addr_add(raddr, (AW+1)'(1));
  end

  // center read shares the write cycle; the address differs because the centre lags
  nes_ram #(.Width(32), .Depth(nes_pkg::StoreLen)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr && (c_q < total_q)),
    .waddr_i (wa_q),
    .wdata_i (wdata_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // max accumulation over neighbours
  logic signed [17:0] tl, ta;
  assign tl = $signed({2'b0, rdata[15:0]}) - $signed({2'b0, pl_q});
  assign ta = $signed({2'b0, pa_q}) - $signed({2'b0, rdata[31:16]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      pslot_q <= cmd_i.slot;
      pin_q   <= inb;
    end
    if (cmd_i.acc) begin
      if (pslot_q == 4'd4) begin
        pl_q <= rdata[15:0]; pa_q <= rdata[31:16];
        dl_q <= '0; da_q <= '0;
      end else if (pin_q) begin
        if (tl > $signed({1'b0, dl_q})) dl_q <= tl[16:0];
        if (ta > $signed({1'b0, da_q})) da_q <= ta[16:0];
      end
    end
    if (cmd_i.mul) begin
      p0_q <= 29'((30'(dl_q) * level_gain_i) >> 12);
      p1_q <= 29'((30'(da_q) * alpha_gain_i) >> 12);
    end
  end

  // combine and clamp; the screen term can exceed the sum, giving a negative result
  logic [57:0] prod;
  logic [59:0] sum;
  always_comb begin
    prod = p0_q * p1_q;
    if (level_mode_on_i && alpha_mode_on_i)
      sum = 60'(p0_q) + 60'(p1_q) - 60'(prod >> 15);
    else if (level_mode_on_i) sum = 60'(p0_q);
    else sum = 60'(p1_q);
  end

  // modes are read live when the result is formed
  assign emit_o = level_mode_on_i || alpha_mode_on_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      if (sum[59]) res_q <= '0;
      else res_q <= (sum > 60'(nes_pkg::ChanMax)) ? 16'(nes_pkg::ChanMax) : sum[15:0];
      fe_q  <= (c_q - PW'(w_q) - PW'(1)) == (total_q - PW'(1));
    end
  end

  assign edge_alpha_o = res_q;
  assign frame_end_o  = fe_q;
endmodule
